[rtl/itdp_pkg.sv]
// shared constants and types for the incremental trial division prime block
package itdp_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned CandW      = 32;
  localparam int unsigned FactW      = 16;

  typedef struct packed {
    logic done;
    logic zero;
  } div_status_t;

endpackage

[rtl/itdp_ram.sv]
// prime table memory with one write port, one read port and registered read
module itdp_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/itdp_div.sv]
// bit-serial remainder unit, one dividend bit per cycle
module itdp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [itdp_pkg::CandW-1:0]  dividend_i,
  input  logic [itdp_pkg::FactW-1:0]  divisor_i,
  output itdp_pkg::div_status_t       status_o
);

  localparam int unsigned StepW = $clog2(itdp_pkg::CandW);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [StepW-1:0]           step_q, step_d;
  logic [itdp_pkg::CandW-1:0] shift_q, shift_d;
  logic [itdp_pkg::FactW-1:0] div_q, div_d;
  logic [itdp_pkg::FactW-1:0] rem_q, rem_d;
  logic [itdp_pkg::FactW:0]   trial;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    shift_d = shift_q;
    div_d   = div_q;
    rem_d   = rem_q;
    trial   = {rem_q, shift_q[itdp_pkg::CandW-1]};
    if (start_i) begin
      busy_d  = 1'b1;
      step_d  = '0;
      shift_d = dividend_i;
      div_d   = divisor_i;
      rem_d   = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      rem_d   = trial[itdp_pkg::FactW-1:0];
      shift_d = {shift_q[itdp_pkg::CandW-2:0], 1'b0};
      step_d  = step_q + 1'b1;
      if (step_q == StepW'(itdp_pkg::CandW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
  end

  assign status_o.done = done_q;
  assign status_o.zero = (rem_q == '0);

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without work");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");

endmodule

[rtl/incremental_trial_division_prime.sv]
// incremental trial division prime generator: sequencer, table and result register
// One item at a time. A candidate below 2 goes straight to the finish step. Otherwise
// each stored prime walked costs a table read, a 16x16 square compare, then a pass of
// the bit-serial remainder unit over all 32 candidate bits, and the finish step follows
// the walk, which covers the stored primes up to those with p*p not above the candidate.
// The table memory is read and written through one port each; no clearing pass is needed
// since only entries below the count are read.
module incremental_trial_division_prime (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [itdp_pkg::CandW-1:0] candidate_i,
  input  logic                       restart_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       is_prime_o,
  output logic [itdp_pkg::FactW-1:0] first_factor_o,
  output logic [itdp_pkg::CntW-1:0]  prime_count_o,
  output logic                       table_full_o
);

  typedef enum logic [2:0] {
    StIdle, StFetch, StSquare, StCmp, StDiv, StFin
  } state_e;

  state_e                          state_q;
  logic [itdp_pkg::CandW-1:0]      cand_q;
  logic [itdp_pkg::CntW-1:0]       count_q;
  logic [itdp_pkg::CntW-1:0]       k_q;
  logic [itdp_pkg::FactW-1:0]      p_q;
  logic [2*itdp_pkg::FactW-1:0]    sq_q;
  logic                            prime_q;
  logic [itdp_pkg::FactW-1:0]      factor_q;

  logic                            out_valid_q;
  logic                            is_prime_q;
  logic [itdp_pkg::FactW-1:0]      first_factor_q;
  logic [itdp_pkg::CntW-1:0]       prime_count_q;
  logic                            table_full_q;

  logic [itdp_pkg::CandW-1:0]      rdata;
  logic                            div_start;
  itdp_pkg::div_status_t           div_st;
  logic                            room;
  logic                            fin_go;
  logic                            tbl_we;

  assign room      = count_q < itdp_pkg::CntW'(itdp_pkg::TableDepth);
  assign fin_go    = (state_q == StFin) && (!out_valid_q || out_ready_i);
  assign tbl_we    = fin_go && prime_q && room;
  assign div_start = (state_q == StCmp) && (sq_q <= cand_q);
  assign in_ready_o = (state_q == StIdle);

  itdp_ram #(
    .Depth (itdp_pkg::TableDepth),
    .Width (itdp_pkg::CandW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (count_q[itdp_pkg::AddrW-1:0]),
    .wdata_i (cand_q),
    .raddr_i (k_q[itdp_pkg::AddrW-1:0]),
    .rdata_o (rdata)
  );

  itdp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cand_q),
    .divisor_i  (p_q),
    .status_o   (div_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      cand_q         <= '0;
      count_q        <= '0;
      k_q            <= '0;
      p_q            <= '0;
      sq_q           <= '0;
      out_valid_q    <= 1'b0;
      prime_q        <= 1'b0;
      factor_q       <= '0;
      is_prime_q     <= 1'b0;
      first_factor_q <= '0;
      prime_count_q  <= '0;
      table_full_q   <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            cand_q   <= candidate_i;
            k_q      <= '0;
            factor_q <= '0;
            if (restart_i) begin
              count_q <= '0;
            end
            if (candidate_i < itdp_pkg::CandW'(2)) begin
              prime_q <= 1'b0;
              state_q <= StFin;
            end else begin
              prime_q <= 1'b1;
              state_q <= StFetch;
            end
          end
        end
        StFetch: begin
          if (k_q == count_q) begin
            state_q <= StFin;
          end else begin
            state_q <= StSquare;
          end
        end
        StSquare: begin
          // a prime of 17 bits or more squares past any 32-bit candidate
          if (rdata[itdp_pkg::CandW-1:itdp_pkg::FactW] != '0) begin
            state_q <= StFin;
          end else begin
            p_q     <= rdata[itdp_pkg::FactW-1:0];
            sq_q    <= rdata[itdp_pkg::FactW-1:0] * rdata[itdp_pkg::FactW-1:0];
            state_q <= StCmp;
          end
        end
        StCmp: begin
          if (sq_q > cand_q) begin
            state_q <= StFin;
          end else begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (div_st.done) begin
            if (div_st.zero) begin
              prime_q  <= 1'b0;
              factor_q <= p_q;
              state_q  <= StFin;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= StFetch;
            end
          end
        end
        StFin: begin
          if (fin_go) begin
            is_prime_q     <= prime_q;
            first_factor_q <= factor_q;
            table_full_q   <= prime_q && !room;
            prime_count_q  <= tbl_we ? count_q + 1'b1 : count_q;
            if (tbl_we) begin
              count_q <= count_q + 1'b1;
            end
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_prime_o     = is_prime_q;
  assign first_factor_o = first_factor_q;
  assign prime_count_o  = prime_count_q;
  assign table_full_o   = table_full_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= itdp_pkg::CntW'(itdp_pkg::TableDepth)) else $error("count overflow");
  a_prime_no_factor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && is_prime_q |-> first_factor_q == '0) else $error("prime with factor");
  a_full_is_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && table_full_q |-> is_prime_q) else $error("full on composite");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSquare |-> k_q < count_q) else $error("read past count");

endmodule
